>>> rtl/grfc_pkg.sv
// Package for the genotype range filter and counter.
// Holds field widths, command and register codes and the queue entry type.
// No dependencies.
package grfc_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned FIELD_W     = 10;
  localparam int unsigned GENO_W      = 2;
  localparam int unsigned WORD_W      = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned BOUND_W     = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned BIT_SEL_W   = 5;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned MID_DEPTH   = 4;
  localparam int unsigned OUT_DEPTH   = 2;

  // Bit 31 holds the first field of a bitmap word.
  localparam logic [BIT_SEL_W-1:0] TOP_BIT = BIT_SEL_W'(WORD_BITS - 1);

  localparam logic               FILTER_MODE_RST = 1'b0;
  localparam logic [BOUND_W-1:0] LOW_BOUND_RST   = 3'd0;
  localparam logic [BOUND_W-1:0] HIGH_BOUND_RST  = 3'd4;
  localparam logic [BOUND_W-1:0] COUNT_LOW_RST   = 3'd0;
  localparam logic [BOUND_W-1:0] COUNT_HIGH_RST  = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    OP_CLEAR      = 2'd0,
    OP_ITEM       = 2'd1,
    OP_READ_WORD  = 2'd2,
    OP_READ_COUNT = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE = 3'd0,
    REG_LOW_BOUND   = 3'd1,
    REG_HIGH_BOUND  = 3'd2,
    REG_COUNT_LOW   = 3'd3,
    REG_COUNT_HIGH  = 3'd4
  } cfg_reg_e;

  // Classified request as it waits between front and back.
  typedef struct packed {
    op_e                op;
    logic [FIELD_W-1:0] field_index;
    logic [WORD_W-1:0]  word_index;
    logic               fail;       // clear the field's pass bit
    logic               count_hit;  // genotype lies inside the count window
    logic               in_range;   // field or word exists
  } item_t;

endpackage

>>> rtl/genotype_range_filter_counter.sv
// Top level of the genotype range filter and counter.
// Depends on grfc_pkg, grfc_front, grfc_fifo and grfc_back.

// The block takes one request per cycle, while full is low, through a
// queue-style input (push/full) and hands results back through a
// queue-style output (pop/empty). A genotype request clears the field's
// pass bit when the genotype fails the filter (range mode: keep low_bound
// <= g < high_bound; not-equal mode: drop g == low_bound) and bumps the
// field's saturating counter when count_low < g < count_high. A bitmap
// read returns the 32-bit pass word (first field of the word in bit 31),
// a count read the field's count; fields or words past the end read as
// zero, and pass bits beyond the last field always read as one. Genotype,
// bitmap-read and count-read requests sustain one per cycle while the
// output queue has room; the counter memory's single read and write port
// sets that figure, with a one-entry forward path so that back-to-back
// updates of the same field see each other. A request moves from the
// request queue through the result stage register, and a read's result
// then enters the output queue to be popped. A clear request first
// waits for the requests ahead of it to leave the result stage, then sets
// every pass bit to one and sweeps all min(FIELDS, 1024) counter entries
// one entry a cycle, during which no request moves past the clear. The
// same sweep runs right after reset; once the request queue fills, full
// stays high until the sweep ends. Configuration writes are taken at any
// time and should be issued only while no request is in flight.
module genotype_range_filter_counter #(
  parameter int unsigned FIELDS      = 1024,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [grfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [grfc_pkg::BOUND_W-1:0]    cfg_wdata_i,
  // request side
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [grfc_pkg::CMD_W-1:0]      cmd_i,
  input  logic [grfc_pkg::FIELD_W-1:0]    field_index_i,
  input  logic [grfc_pkg::GENO_W-1:0]     genotype_i,
  input  logic [grfc_pkg::WORD_W-1:0]     word_index_i,
  // result side
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic [grfc_pkg::DATA_W-1:0]     read_data_o
);

  localparam int unsigned ITEM_W = $bits(grfc_pkg::item_t);

  grfc_pkg::item_t             front_item;
  grfc_pkg::item_t             head_item;
  logic [ITEM_W-1:0]           head_bits;
  logic                        mid_empty;
  logic                        mid_pop;
  logic                        out_full;
  logic                        out_push;
  logic [grfc_pkg::DATA_W-1:0] out_data;

  // Classify each request against the current bounds.
  grfc_front #(
    .FIELDS (FIELDS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd_i),
    .field_index_i (field_index_i),
    .genotype_i    (genotype_i),
    .word_index_i  (word_index_i),
    .item_o        (front_item)
  );

  // Hold classified requests so the back end can stall on its own.
  grfc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (grfc_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (front_item),
    .full_o  (full_o),
    .pop_i   (mid_pop),
    .rdata_o (head_bits),
    .empty_o (mid_empty)
  );

  assign head_item = grfc_pkg::item_t'(head_bits);

  // Apply updates, serve reads, run the clearing pass.
  grfc_back #(
    .FIELDS      (FIELDS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (!mid_empty),
    .q_item_i   (head_item),
    .q_pop_o    (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_data_o (out_data)
  );

  // Park finished results until the consumer pops them.
  grfc_fifo #(
    .WIDTH (grfc_pkg::DATA_W),
    .DEPTH (grfc_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_data),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .rdata_o (read_data_o),
    .empty_o (empty_o)
  );

endmodule

>>> rtl/grfc_fifo.sv
// Small first-in first-out queue of flip-flops.
// Generic; uses no package.
module grfc_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/grfc_front.sv
// Front end: configuration registers and request classification.
// Depends on grfc_pkg.
module grfc_front #(
  parameter int unsigned FIELDS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [grfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [grfc_pkg::BOUND_W-1:0]    cfg_wdata_i,
  input  logic [grfc_pkg::CMD_W-1:0]      cmd_i,
  input  logic [grfc_pkg::FIELD_W-1:0]    field_index_i,
  input  logic [grfc_pkg::GENO_W-1:0]     genotype_i,
  input  logic [grfc_pkg::WORD_W-1:0]     word_index_i,
  output grfc_pkg::item_t                 item_o
);

  localparam int unsigned NWORDS = (FIELDS + 31) / 32;

  logic                         filter_mode_q;
  logic [grfc_pkg::BOUND_W-1:0] low_bound_q, high_bound_q;
  logic [grfc_pkg::BOUND_W-1:0] count_low_q, count_high_q;
  logic [grfc_pkg::BOUND_W-1:0] geno;
  grfc_pkg::op_e                op;
  logic                         field_ok, word_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q <= grfc_pkg::FILTER_MODE_RST;
      low_bound_q   <= grfc_pkg::LOW_BOUND_RST;
      high_bound_q  <= grfc_pkg::HIGH_BOUND_RST;
      count_low_q   <= grfc_pkg::COUNT_LOW_RST;
      count_high_q  <= grfc_pkg::COUNT_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        grfc_pkg::REG_FILTER_MODE: filter_mode_q <= cfg_wdata_i[0];
        grfc_pkg::REG_LOW_BOUND:   low_bound_q   <= cfg_wdata_i;
        grfc_pkg::REG_HIGH_BOUND:  high_bound_q  <= cfg_wdata_i;
        grfc_pkg::REG_COUNT_LOW:   count_low_q   <= cfg_wdata_i;
        grfc_pkg::REG_COUNT_HIGH:  count_high_q  <= cfg_wdata_i;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign geno     = {1'b0, genotype_i};
  assign op       = grfc_pkg::op_e'(cmd_i);
  assign field_ok = (32'(field_index_i) < 32'(FIELDS));
  assign word_ok  = (32'(word_index_i) < 32'(NWORDS));

  always_comb begin
    item_o.op          = op;
    item_o.field_index = field_index_i;
    item_o.word_index  = word_index_i;
    item_o.fail        = filter_mode_q ? (geno == low_bound_q)
                                       : !((geno >= low_bound_q) && (geno < high_bound_q));
    item_o.count_hit   = (geno > count_low_q) && (geno < count_high_q);
    item_o.in_range    = (op == grfc_pkg::OP_READ_WORD) ? word_ok : field_ok;
  end

endmodule

>>> rtl/grfc_back.sv
// Back end: pass bitmap, per-field counter memory, clearing pass, result stage.
// Depends on grfc_pkg.
module grfc_back #(
  parameter int unsigned FIELDS      = 1024,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  grfc_pkg::item_t              q_item_i,
  output logic                         q_pop_o,
  input  logic                         out_full_i,
  output logic                         out_push_o,
  output logic [grfc_pkg::DATA_W-1:0]  out_data_o
);

  localparam int unsigned MAX_FIELDS = 1 << grfc_pkg::FIELD_W;
  localparam int unsigned MAX_WORDS  = 1 << grfc_pkg::WORD_W;
  localparam int unsigned CNT_DEPTH  = (FIELDS < MAX_FIELDS) ? FIELDS : MAX_FIELDS;
  localparam int unsigned CAW        = $clog2(CNT_DEPTH);
  localparam int unsigned NWORDS     = (FIELDS + 31) / 32;
  localparam int unsigned PW         = (NWORDS < MAX_WORDS) ? NWORDS : MAX_WORDS;
  localparam int unsigned PAW        = (PW > 1) ? $clog2(PW) : 1;

  // Pass bitmap in flip-flops, counters in a memory.
  logic [grfc_pkg::WORD_BITS-1:0] pass_q [PW];
  logic [COUNT_WIDTH-1:0]         cnt_mem [CNT_DEPTH];
  logic [COUNT_WIDTH-1:0]         rdata_q;

  grfc_pkg::item_t        b_q;
  logic                   b_vld_q;
  logic                   fwd_vld_q;
  logic [CAW-1:0]         fwd_addr_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;
  logic                   sweep_act_q;
  logic [CAW-1:0]         sweep_addr_q;

  logic                   adv, a_take, clr_go, rd_en;
  logic                   b_res, b_cnt_wr, b_pass_wr, fwd_hit;
  logic [CAW-1:0]         a_addr, b_addr;
  logic [COUNT_WIDTH-1:0] cur, cnt_next;
  logic                   mem_we;
  logic [CAW-1:0]         mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [PAW-1:0]         pidx;
  logic [grfc_pkg::BIT_SEL_W-1:0] bsel;

  assign b_res  = (b_q.op == grfc_pkg::OP_READ_WORD) || (b_q.op == grfc_pkg::OP_READ_COUNT);
  assign adv    = !b_vld_q || !(b_res && out_full_i);
  assign a_take = q_valid_i && (q_item_i.op != grfc_pkg::OP_CLEAR) && !sweep_act_q && adv;
  // Clear waits for the result stage to drain, then starts the clearing pass.
  assign clr_go = q_valid_i && (q_item_i.op == grfc_pkg::OP_CLEAR) && !sweep_act_q && !b_vld_q;
  assign q_pop_o = a_take || clr_go;

  assign a_addr = q_item_i.field_index[CAW-1:0];
  assign b_addr = b_q.field_index[CAW-1:0];
  assign rd_en  = a_take && q_item_i.in_range &&
                  ((q_item_i.op == grfc_pkg::OP_ITEM) || (q_item_i.op == grfc_pkg::OP_READ_COUNT));

  // The request ahead wrote at the edge this one read: take its value.
  assign fwd_hit  = fwd_vld_q && (fwd_addr_q == b_addr);
  assign cur      = fwd_hit ? fwd_data_q : rdata_q;
  assign cnt_next = cur + COUNT_WIDTH'(1);

  assign b_cnt_wr  = b_vld_q && (b_q.op == grfc_pkg::OP_ITEM) && b_q.in_range &&
                     b_q.count_hit && (cur != '1);
  assign b_pass_wr = b_vld_q && (b_q.op == grfc_pkg::OP_ITEM) && b_q.in_range && b_q.fail;

  assign pidx = b_q.field_index[PAW+4:5];
  assign bsel = grfc_pkg::TOP_BIT - b_q.field_index[4:0];

  always_comb begin
    if (sweep_act_q) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = b_cnt_wr;
      mem_waddr = b_addr;
      mem_wdata = cnt_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= cnt_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q      <= 1'b0;
      fwd_vld_q    <= 1'b0;
      sweep_act_q  <= 1'b1;
      sweep_addr_q <= '0;
    end else begin
      if (adv) begin
        b_vld_q   <= a_take;
        fwd_vld_q <= b_cnt_wr;
      end
      if (clr_go) begin
        sweep_act_q  <= 1'b1;
        sweep_addr_q <= '0;
      end else if (sweep_act_q) begin
        if (sweep_addr_q == CAW'(CNT_DEPTH - 1)) begin
          sweep_act_q <= 1'b0;
        end
        sweep_addr_q <= sweep_addr_q + CAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && a_take) begin
      b_q <= q_item_i;
    end
    if (adv) begin
      fwd_addr_q <= b_addr;
      fwd_data_q <= cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(PW); i++) pass_q[i] <= '1;
    end else if (clr_go) begin
      for (int i = 0; i < int'(PW); i++) pass_q[i] <= '1;
    end else if (b_pass_wr) begin
      pass_q[pidx][bsel] <= 1'b0;
    end
  end

  assign out_push_o = b_vld_q && b_res && !out_full_i;

  always_comb begin
    if (!b_q.in_range) begin
      out_data_o = '0;
    end else if (b_q.op == grfc_pkg::OP_READ_WORD) begin
      out_data_o = pass_q[b_q.word_index[PAW-1:0]];
    end else begin
      out_data_o = grfc_pkg::DATA_W'(cur);
    end
  end

`ifndef SYNTHESIS
  a_no_clear_in_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |-> (b_q.op != grfc_pkg::OP_CLEAR))
    else $error("clear request reached the result stage");

  a_sweep_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_act_q |-> (!b_vld_q && !a_take))
    else $error("request in flight during counter clearing pass");

  a_sweep_no_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_act_q |-> !fwd_vld_q)
    else $error("stale forward value during clearing pass");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && !adv) |=> (b_vld_q && $stable(rdata_q) && $stable(fwd_vld_q)))
    else $error("result stage lost its read data while stalled");
`endif

endmodule
